// ----- hdl/pee_pkg.sv -----
package pee_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RESULT_WIDTH = 32;
    localparam int STATUS_WIDTH = 3;

    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;
    localparam logic [7:0] CH_POW = 8'h5E;
    localparam logic [7:0] CH_MOD = 8'h25;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_NEGEXP    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_POW
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_cmd;

    typedef struct packed {
        logic    done;
        logic    err;
        t_status err_code;
    } t_alu_sts;

endpackage

// ----- hdl/pee_ram.sv -----
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/pee_alu.sv -----
module pee_alu #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pee_pkg::t_alu_cmd      i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_lhs,
    input  logic [VALUE_WIDTH-1:0] i_rhs,
    output pee_pkg::t_alu_sts      o_sts,
    output logic [VALUE_WIDTH-1:0] o_res
);
    import pee_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_POW,
        S_FIN
    } t_state;

    t_state                 r_state;
    t_op                    r_op;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_a;
    logic [VALUE_WIDTH-1:0] r_b;
    logic [VALUE_WIDTH-1:0] r_q;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_res;
    logic                   r_na;
    logic                   r_nb;
    logic                   r_done;
    logic                   r_err;
    t_status                r_code;

    logic [VALUE_WIDTH-1:0] mag_l;
    logic [VALUE_WIDTH-1:0] mag_r;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] shifted;

    assign mag_l = i_lhs[VALUE_WIDTH-1] ? -i_lhs : i_lhs;
    assign mag_r = i_rhs[VALUE_WIDTH-1] ? -i_rhs : i_rhs;
    assign shifted = {r_rem[VALUE_WIDTH-2:0], r_a[VALUE_WIDTH-1]};
    assign trial = {r_rem[VALUE_WIDTH-1], shifted} - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
            r_code  <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_op   <= i_cmd.op;
                        r_err  <= 1'b0;
                        r_code <= ST_OK;
                        r_cnt  <= '0;
                        r_na   <= i_lhs[VALUE_WIDTH-1];
                        r_nb   <= i_rhs[VALUE_WIDTH-1];
                        unique case (i_cmd.op)
                            OP_ADD: begin
                                r_res   <= i_lhs + i_rhs;
                                r_state <= S_FIN;
                            end
                            OP_SUB: begin
                                r_res   <= i_lhs - i_rhs;
                                r_state <= S_FIN;
                            end
                            OP_MUL: begin
                                r_res   <= i_lhs * i_rhs;
                                r_state <= S_FIN;
                            end
                            OP_DIV, OP_MOD: begin
                                if (i_rhs == '0) begin
                                    r_res   <= '0;
                                    r_err   <= 1'b1;
                                    r_code  <= ST_DIVZERO;
                                    r_state <= S_FIN;
                                end else begin
                                    r_a     <= mag_l;
                                    r_b     <= mag_r;
                                    r_rem   <= '0;
                                    r_q     <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            OP_POW: begin
                                if (i_rhs[VALUE_WIDTH-1]) begin
                                    r_res   <= '0;
                                    r_err   <= 1'b1;
                                    r_code  <= ST_NEGEXP;
                                    r_state <= S_FIN;
                                end else begin
                                    r_a     <= i_lhs;
                                    r_b     <= i_rhs;
                                    r_res   <= VALUE_WIDTH'(1);
                                    r_state <= S_POW;
                                end
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_DIV: begin
                    r_a <= {r_a[VALUE_WIDTH-2:0], 1'b0};
                    if (!trial[VALUE_WIDTH]) begin
                        r_rem <= trial[VALUE_WIDTH-1:0];
                        r_q   <= {r_q[VALUE_WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem <= shifted;
                        r_q   <= {r_q[VALUE_WIDTH-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(VALUE_WIDTH - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_POW: begin
                    if (r_b[0]) begin
                        r_res <= r_res * r_a;
                    end
                    r_a   <= r_a * r_a;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(VALUE_WIDTH - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_op == OP_DIV && !r_err) begin
                        r_res <= (r_na != r_nb) ? -r_q : r_q;
                    end else if (r_op == OP_MOD && !r_err) begin
                        r_res <= r_na ? -r_rem : r_rem;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.err      = r_err;
    assign o_sts.err_code = r_code;
    assign o_res          = r_res;
endmodule

// ----- hdl/pee_ctrl.sv -----
module pee_ctrl #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pee_pkg::RESULT_WIDTH-1:0]    o_result_value,
    output logic [pee_pkg::STATUS_WIDTH-1:0]    o_status,
    output logic                                o_we,
    output logic [$clog2(STACK_DEPTH)-1:0]      o_waddr,
    output logic [VALUE_WIDTH-1:0]              o_wdata,
    output logic [$clog2(STACK_DEPTH)-1:0]      o_raddr,
    input  logic [VALUE_WIDTH-1:0]              i_rdata,
    output pee_pkg::t_alu_cmd                   o_cmd,
    output logic [VALUE_WIDTH-1:0]              o_lhs,
    output logic [VALUE_WIDTH-1:0]              o_rhs,
    input  pee_pkg::t_alu_sts                   i_sts,
    input  logic [VALUE_WIDTH-1:0]              i_res
);
    import pee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_RHS,
        S_RD_LHS,
        S_LHS,
        S_ALU,
        S_RD_TOP,
        S_END,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [PW-1:0]          r_sp;
    t_status                r_err;
    t_op                    r_op;
    logic                   r_last;
    logic [VALUE_WIDTH-1:0] r_rhs;
    logic [VALUE_WIDTH-1:0] r_lhs;
    logic                   r_start;
    logic                   r_we;
    logic [AW-1:0]          r_waddr;
    logic [VALUE_WIDTH-1:0] r_wdata;
    logic [AW-1:0]          r_raddr;
    logic                   r_ovalid;
    logic [RESULT_WIDTH-1:0] r_value;
    t_status                r_status;

    logic dec_digit;
    logic is_op;
    t_op  dec_op;

    always_comb begin
        is_op  = 1'b1;
        dec_op = OP_ADD;
        unique case (i_char_code)
            CH_ADD:  dec_op = OP_ADD;
            CH_SUB:  dec_op = OP_SUB;
            CH_MUL:  dec_op = OP_MUL;
            CH_DIV:  dec_op = OP_DIV;
            CH_MOD:  dec_op = OP_MOD;
            CH_POW:  dec_op = OP_POW;
            default: is_op = 1'b0;
        endcase
    end

    assign dec_digit = i_char_code >= CH_ZERO && i_char_code <= CH_NINE;

    always_ff @(posedge i_clk) begin
        r_we    <= 1'b0;
        r_start <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
            r_we     <= 1'b0;
            r_start  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_last  <= i_last;
                        r_op    <= dec_op;
                        r_state <= i_last ? S_RD_TOP : S_IDLE;
                        if (dec_digit) begin
                            if (r_sp == PW'(STACK_DEPTH)) begin
                                if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                            end else begin
                                r_we    <= 1'b1;
                                r_waddr <= r_sp[AW-1:0];
                                r_wdata <= VALUE_WIDTH'(i_char_code - CH_ZERO);
                                r_sp    <= r_sp + 1'b1;
                            end
                        end else if (is_op) begin
                            if (r_sp < PW'(2)) begin
                                if (r_err == ST_OK) r_err <= ST_UNDERFLOW;
                            end else begin
                                r_raddr <= AW'(r_sp - PW'(1));
                                r_state <= S_RD_RHS;
                            end
                        end
                    end
                end
                S_RD_RHS: begin
                    r_raddr <= AW'(r_sp - PW'(2));
                    r_state <= S_RD_LHS;
                end
                S_RD_LHS: begin
                    r_rhs   <= i_rdata;
                    r_state <= S_LHS;
                end
                S_LHS: begin
                    r_lhs   <= i_rdata;
                    r_start <= 1'b1;
                    r_state <= S_ALU;
                end
                S_ALU: begin
                    if (i_sts.done) begin
                        if (i_sts.err && r_err == ST_OK) r_err <= i_sts.err_code;
                        r_we    <= 1'b1;
                        r_waddr <= AW'(r_sp - PW'(2));
                        r_wdata <= i_res;
                        r_sp    <= r_sp - 1'b1;
                        r_state <= r_last ? S_RD_TOP : S_IDLE;
                    end
                end
                S_RD_TOP: begin
                    r_raddr <= AW'(r_sp - PW'(1));
                    r_state <= S_END;
                end
                S_END: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        if (r_sp == '0) begin
                            r_value  <= '0;
                            r_status <= (r_err == ST_OK) ? ST_EMPTY : r_err;
                        end else begin
                            r_value  <= RESULT_WIDTH'(signed'(i_rdata));
                            r_status <= r_err;
                        end
                        r_sp    <= '0;
                        r_err   <= ST_OK;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_result_value = r_value;
    assign o_status       = r_status;
    assign o_we           = r_we;
    assign o_waddr        = r_waddr;
    assign o_wdata        = r_wdata;
    assign o_raddr        = r_raddr;
    assign o_cmd.start    = r_start;
    assign o_cmd.op       = r_op;
    assign o_lhs          = r_lhs;
    assign o_rhs          = r_rhs;
endmodule

// ----- hdl/postfix_expression_evaluator.sv -----
// Postfix integer expression evaluator.
// The input channel takes one word per character of the expression, with
// i_last marking the final character. Digits are pushed onto an operand
// stack held in a RAM; the operators + - * / % ^ pop two operands and push
// the wrapping result. Other characters are ignored.
// A digit or an ignored character is handled in the idle state. An operator
// reads its two operands from the stack RAM and waits for the arithmetic unit;
// for / % ^ that unit runs a one-bit-per-cycle divider or a one-bit-per-cycle
// square-and-multiply loop, except for a division by zero or a negative exponent.
// After a word marked last, one result word carrying the top of the stack
// and the first error of the expression is presented on the output channel,
// and the stack and error are cleared.
// The output register lets the next expression start while a result waits;
// if a new result is ready before the old one is taken, the block waits.
// Reset empties the stack and clears the error; the RAM is not cleared.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_char_code,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pee_pkg::RESULT_WIDTH-1:0] o_result_value,
    output logic [pee_pkg::STATUS_WIDTH-1:0] o_status
);
    import pee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0] rdata;
    logic [VALUE_WIDTH-1:0] lhs;
    logic [VALUE_WIDTH-1:0] rhs;
    logic [VALUE_WIDTH-1:0] res;
    t_alu_cmd               cmd;
    t_alu_sts               sts;

    pee_ctrl #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_cmd          (cmd),
        .o_lhs          (lhs),
        .o_rhs          (rhs),
        .i_sts          (sts),
        .i_res          (res)
    );

    pee_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_lhs   (lhs),
        .i_rhs   (rhs),
        .o_sts   (sts),
        .o_res   (res)
    );

    pee_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );
endmodule

// ----- tb/postfix_expression_evaluator_test.sv -----
`timescale 1ns / 1ps

module postfix_expression_evaluator_test;
    import pee_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int MAX_CYCLES = 400000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       known;
        logic [31:0] value;
        t_status    status;
    } t_row;

    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_char_code;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [RESULT_WIDTH-1:0] o_result_value;
    logic [STATUS_WIDTH-1:0] o_status;

    postfix_expression_evaluator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_char_code(i_char_code), .i_last(i_last),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_value(o_result_value), .o_status(o_status)
    );

    logic [31:0] calc_stack [DEPTH];
    int          calc_depth;
    t_status     calc_error;
    t_answer     answers_due[$];
    int          fails;
    int          results_seen;
    int          words_sent;
    bit          rx_stall_en;
    bit          hold_off;
    bit          tx_stall_en;
    t_row        rows[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(MAX_CYCLES * 8);
        $display("postfix_expression_evaluator verification failed");
        $finish;
    end

    function automatic void note_error(t_status code);
        if (calc_error == ST_OK) begin
            calc_error = code;
        end
    endfunction

    function automatic logic [31:0] raise_power(logic [31:0] b, logic [31:0] e);
        logic [31:0] r;
        r = 32'd1;
        for (int k = 0; k < 32; k++) begin
            if (e[k]) begin
                r = r * b;
            end
            b = b * b;
        end
        return r;
    endfunction

    function automatic logic [31:0] apply_op(logic [7:0] ch, logic [31:0] a,
                                             logic [31:0] b);
        logic [31:0] ua, ub, q, rm;
        case (ch)
            CH_ADD: return a + b;
            CH_SUB: return a - b;
            CH_MUL: return a * b;
            CH_POW: begin
                if (b[31]) begin
                    note_error(ST_NEGEXP);
                    return 32'd0;
                end
                return raise_power(a, b);
            end
            default: begin
                if (b == 0) begin
                    note_error(ST_DIVZERO);
                    return 32'd0;
                end
                ua = a[31] ? -a : a;
                ub = b[31] ? -b : b;
                q = ua / ub;
                rm = ua % ub;
                if (ch == CH_DIV) begin
                    return (a[31] != b[31]) ? -q : q;
                end
                return a[31] ? -rm : rm;
            end
        endcase
    endfunction

    function automatic bit evaluate_char(logic [7:0] ch, logic last, output t_answer ans);
        logic [31:0] a, b;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (calc_depth >= DEPTH) begin
                note_error(ST_OVERFLOW);
            end else begin
                calc_stack[calc_depth] = 32'(ch - CH_ZERO);
                calc_depth++;
            end
        end else if (ch inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_POW}) begin
            if (calc_depth < 2) begin
                note_error(ST_UNDERFLOW);
            end else begin
                b = calc_stack[calc_depth - 1];
                a = calc_stack[calc_depth - 2];
                calc_depth -= 2;
                calc_stack[calc_depth] = apply_op(ch, a, b);
                calc_depth++;
            end
        end
        if (!last) begin
            return 0;
        end
        ans.status = calc_error;
        ans.value = 32'd0;
        if (calc_depth >= 1) begin
            ans.value = calc_stack[calc_depth - 1];
        end else if (ans.status == ST_OK) begin
            ans.status = ST_EMPTY;
        end
        calc_depth = 0;
        calc_error = ST_OK;
        return 1;
    endfunction

    task automatic send_word(logic [7:0] ch, logic last, t_row row);
        t_answer ans;
        if (tx_stall_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= ch;
        i_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        if (evaluate_char(ch, last, ans)) begin
            if (row.known && (ans.value !== row.value || ans.status !== row.status)) begin
                $display("%0t table row disagrees: expected %h/%0d, computed %h/%0d",
                         $time, row.value, row.status, ans.value, ans.status);
                fails++;
            end
            answers_due.push_back(ans);
        end
        @(negedge i_clk);
    endtask

    task automatic send_plain(logic [7:0] ch, logic last);
        t_row r;
        r.known = 1'b0;
        send_word(ch, last, r);
    endtask

    function automatic void add_row(string s, bit known, logic [31:0] v, t_status st);
        t_row r;
        for (int k = 0; k < s.len(); k++) begin
            r.ch = s[k];
            r.last = (k == s.len() - 1);
            r.known = known && r.last;
            r.value = v;
            r.status = st;
            rows.push_back(r);
        end
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_op();
        logic [7:0] ops[6] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_POW};
        return ops[$urandom_range(0, 5)];
    endfunction

    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                $display("%0t unexpected result: actual %h/%0d", $time,
                         o_result_value, o_status);
                fails++;
            end else begin
                exp_ans = answers_due.pop_front();
                if (o_result_value !== exp_ans.value) begin
                    $display("%0t value mismatch: expected %h, actual %h", $time,
                             exp_ans.value, o_result_value);
                    fails++;
                end
                if (o_status !== exp_ans.status) begin
                    $display("%0t status mismatch: expected %0d, actual %0d", $time,
                             exp_ans.status, o_status);
                    fails++;
                end
            end
        end
    end

    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
                i_ready <= 1'b1;
            end else if (rx_stall_en && $urandom_range(0, 6) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int n, ops_left;
        fails = 0;
        results_seen = 0;
        words_sent = 0;
        calc_depth = 0;
        calc_error = ST_OK;
        rx_stall_en = 1'b1;
        tx_stall_en = 1'b1;
        hold_off = 1'b0;
        i_valid = 1'b0;
        i_char_code = 8'd0;
        i_last = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row("9", 1, 32'd9, ST_OK);
        add_row("x", 1, 32'd0, ST_EMPTY);
        add_row("+", 1, 32'd0, ST_UNDERFLOW);
        add_row("50/", 1, 32'd0, ST_DIVZERO);
        add_row("50%", 1, 32'd0, ST_DIVZERO);
        add_row("201-^", 1, 32'd0, ST_NEGEXP);
        add_row("00^", 1, 32'd1, ST_OK);
        add_row("34+2*7-", 1, 32'd7, ST_OK);
        add_row("07-3/", 1, 32'hFFFFFFFE, ST_OK);
        add_row("07-3%", 1, 32'hFFFFFFFF, ST_OK);
        add_row("99*9*9*9*9*9*9*9*9*9*", 0, 32'd0, ST_OK);
        add_row("29+ 5", 1, 32'd5, ST_OK);
        add_row("1+50/2", 1, 32'd2, ST_UNDERFLOW);
        foreach (rows[k]) begin
            send_word(rows[k].ch, rows[k].last, rows[k]);
        end
        for (int k = 0; k < DEPTH + 2; k++) begin
            send_plain(k == DEPTH + 1 ? CH_ADD : pick_digit(), k == DEPTH + 1);
        end
        for (int k = 0; k < 32; k++) begin
            send_plain(CH_NINE, 1'b0);
        end
        send_plain(8'hFF, 1'b1);
        send_plain(8'h00, 1'b1);

        hold_off = 1'b1;
        for (int k = 0; k < 30; k++) begin
            send_plain(pick_digit(), 1'b1);
        end
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        while (words_sent < 1100) begin
            if (words_sent > 950) begin
                rx_stall_en = 1'b0;
                tx_stall_en = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    send_plain(8'($urandom_range(0, 255)), k == n - 1);
                end
            end else begin
                n = $urandom_range(1, 6);
                send_plain(pick_digit(), 1'b0);
                ops_left = 0;
                for (int k = 1; k < n; k++) begin
                    send_plain(pick_digit(), 1'b0);
                    ops_left++;
                    if ($urandom_range(0, 1) == 1 && ops_left > 0) begin
                        send_plain(pick_op(), 1'b0);
                        ops_left--;
                    end
                end
                while (ops_left > 1) begin
                    send_plain(pick_op(), 1'b0);
                    ops_left--;
                end
                send_plain(ops_left == 1 ? pick_op() : 8'h20, 1'b1);
            end
        end

        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Sent %0d characters in directed and random expressions,", words_sent);
        $display("checked %0d results, including every error status.", results_seen);
        if (fails == 0) begin
            $display("postfix_expression_evaluator verification clean");
        end else begin
            $display("postfix_expression_evaluator verification failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/pee_pkg.sv
hdl/pee_ram.sv
hdl/pee_alu.sv
hdl/pee_ctrl.sv
hdl/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_test.sv
